// ===== hdl/jpq_pkg.sv =====
// Shared types, codes and field widths of the job priority queue scheduler.
package jpq_pkg;

    localparam int TAG_W   = 8;
    localparam int ARR_W   = 11;
    localparam int DUR_W   = 10;
    localparam int KEY_W   = ARR_W + DUR_W;
    localparam int ENTRY_W = TAG_W + KEY_W;
    localparam int TIME_W  = 16;
    localparam int SUM_W   = 32;

    // Input item kind, carried on s_tuser
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Result status, carried on m_tuser
    typedef enum logic [1:0] {
        STAT_ENQ   = 2'd0,
        STAT_DEQ   = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_POP,
        ST_DONE
    } state_t;

    // Dequeue event handed to the service-clock unit
    typedef struct packed {
        logic             pop;
        logic [ARR_W-1:0] arrival;
        logic [DUR_W-1:0] duration;
    } svc_req_t;

    // Service-clock unit answer
    typedef struct packed {
        logic [TIME_W-1:0] start_min;
        logic [TIME_W-1:0] wait_min;
        logic [SUM_W-1:0]  total_wait;
        logic [SUM_W-1:0]  total_busy;
    } svc_rsp_t;

endpackage

// ===== hdl/jpq_ram.sv =====
// Simple dual-port entry memory with a registered read port.
module jpq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [jpq_pkg::ENTRY_W-1:0] wdata,
    input  logic [AW-1:0]               raddr,
    output logic [jpq_pkg::ENTRY_W-1:0] rdata
);
    import jpq_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/jpq_svc.sv =====
// Service clock and saturating wait/busy totals, updated on each dequeue.
module jpq_svc (
    input  logic              clk,
    input  logic              rst_n,
    input  jpq_pkg::svc_req_t req,
    output jpq_pkg::svc_rsp_t rsp
);
    import jpq_pkg::*;

    logic [TIME_W-1:0] clock_reg, clock_next;
    logic [SUM_W-1:0]  wait_sum_reg, wait_sum_next;
    logic [SUM_W-1:0]  busy_sum_reg, busy_sum_next;

    logic [TIME_W-1:0] arr16;
    logic [TIME_W-1:0] start_min;
    logic [TIME_W-1:0] wait_min;
    logic [TIME_W:0]   fin;
    logic [SUM_W:0]    wsum;
    logic [SUM_W:0]    bsum;

    always_comb
    begin
        arr16     = TIME_W'(req.arrival);
        start_min = (clock_reg > arr16) ? clock_reg : arr16;
        wait_min  = start_min - arr16;
        fin       = {1'b0, start_min} + (TIME_W + 1)'(req.duration);
        wsum      = {1'b0, wait_sum_reg} + (SUM_W + 1)'(wait_min);
        bsum      = {1'b0, busy_sum_reg} + (SUM_W + 1)'(req.duration);
        // saturate the clock and both totals
        clock_next    = fin[TIME_W]  ? '1 : fin[TIME_W-1:0];
        wait_sum_next = wsum[SUM_W]  ? '1 : wsum[SUM_W-1:0];
        busy_sum_next = bsum[SUM_W]  ? '1 : bsum[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg    <= '0;
            wait_sum_reg <= '0;
            busy_sum_reg <= '0;
        end
        else if (req.pop)
        begin
            clock_reg    <= clock_next;
            wait_sum_reg <= wait_sum_next;
            busy_sum_reg <= busy_sum_next;
        end
    end

    assign rsp.start_min  = start_min;
    assign rsp.wait_min   = wait_min;
    assign rsp.total_wait = wait_sum_reg;
    assign rsp.total_busy = busy_sum_reg;

endmodule

// ===== hdl/job_priority_queue_scheduler.sv =====
// Top level of the job priority queue scheduler: sorted job list in memory.
//
//  channel | dir | tdata (low bit first)                         | tuser
//  --------+-----+-----------------------------------------------+-------------
//  s_*     | in  | job_tag, arrival_minute, duration, pad to 32  | func
//  m_*     | out | out_tag, out_arrival, out_duration,           | status
//          |     | start_time, wait_time, total_wait,            |
//          |     | total_busy, occupancy, pad to whole bytes     |
//
// Steps: a dequeue passes accept, memory read and result; an empty dequeue
// or a full enqueue goes from accept straight to result. An enqueue moves
// each stored job with a larger key up, one job per cycle through the entry
// memory, reading one slot below while writing the slot above.
// Reset: asynchronous, active low; clears the count, head pointer, service
// clock and totals. The memory needs no clearing, since only held jobs are read.
// Stalls: a finished result waits in the output register; the next item is
// taken meanwhile and holds in its last state until the register frees.
module job_priority_queue_scheduler #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // job_tag[7:0], arrival_minute[18:8], duration[28:19], zero[31:29]
    input  logic [31:0] s_tdata,
    // func[0]
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // out_tag[7:0], out_arrival[18:8], out_duration[28:19], start_time[44:29],
    // wait_time[60:45], total_wait[92:61], total_busy[124:93],
    // occupancy[125 +: CW], zero above
    output logic [((125 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);
    import jpq_pkg::*;

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W = ((125 + CW + 7) / 8) * 8;
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // Map a position in the list to a memory slot (circular, head at zero).
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW-1:0] lpos);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, lpos};
        if (s >= DEPTH_A)
        begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg,  head_next;
    logic [AW-1:0] pos_reg,   pos_next;

    // accepted item (payload, no reset)
    logic [TAG_W-1:0] item_tag_reg, item_tag_next;
    logic [ARR_W-1:0] item_arr_reg, item_arr_next;
    logic [DUR_W-1:0] item_dur_reg, item_dur_next;

    // result being built
    status_t           res_status_reg, res_status_next;
    logic [TAG_W-1:0]  res_tag_reg,    res_tag_next;
    logic [ARR_W-1:0]  res_arr_reg,    res_arr_next;
    logic [DUR_W-1:0]  res_dur_reg,    res_dur_next;
    logic [TIME_W-1:0] res_start_reg,  res_start_next;
    logic [TIME_W-1:0] res_wait_reg,   res_wait_next;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg,  m_tdata_next;
    status_t          m_tuser_reg,  m_tuser_next;

    // -------------------------------------------------------------- datapath
    logic               in_fire;
    logic               in_func;
    logic               out_load;
    logic               do_shift;
    logic [KEY_W-1:0]   item_key;
    logic [AW-1:0]      rd_lpos;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    svc_req_t           svc_req;
    svc_rsp_t           svc_rsp;

    assign in_fire  = s_tvalid && s_tready;
    assign in_func  = s_tuser;
    assign item_key = {item_arr_reg, item_dur_reg};
    // move the stored job up while its key is strictly greater (FIFO on ties)
    assign do_shift = (pos_reg != '0) && (ram_rdata[KEY_W-1:0] > item_key);
    assign out_load = !m_tvalid_reg || m_tready;

    jpq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    jpq_svc u_svc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (svc_req),
        .rsp   (svc_rsp)
    );

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_func == FUNC_ENQ)
                    begin
                        state_next = (count_reg == DEPTH_C) ? ST_DONE : ST_SHIFT;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_DONE : ST_POP;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (!do_shift)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------ control outputs
    always_comb
    begin
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = slot_of(head_reg, pos_reg);
        ram_wdata     = do_shift ? ram_rdata : {item_tag_reg, item_arr_reg, item_dur_reg};
        rd_lpos       = '0;
        svc_req.pop      = 1'b0;
        svc_req.arrival  = ram_rdata[KEY_W-1:DUR_W];
        svc_req.duration = ram_rdata[DUR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                // fetch the tail for an insert, the head for a pop
                if (in_func == FUNC_ENQ && count_reg != '0)
                begin
                    rd_lpos = count_reg[AW-1:0] - AW'(1);
                end
            end
            ST_SHIFT:
            begin
                ram_we = 1'b1;
                // prefetch the slot below the next write position
                if (do_shift && pos_reg > AW'(1))
                begin
                    rd_lpos = pos_reg - AW'(2);
                end
            end
            ST_POP:
            begin
                svc_req.pop = 1'b1;
            end
            ST_DONE:
            begin
                rd_lpos = '0;
            end
            default:
            begin
                rd_lpos = '0;
            end
        endcase
        ram_raddr = slot_of(head_reg, rd_lpos);
    end

    // ------------------------------------------------------ register updates
    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        pos_next        = pos_reg;
        item_tag_next   = item_tag_reg;
        item_arr_next   = item_arr_reg;
        item_dur_next   = item_dur_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_arr_next    = res_arr_reg;
        res_dur_next    = res_dur_reg;
        res_start_next  = res_start_reg;
        res_wait_next   = res_wait_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_tag_next  = s_tdata[7:0];
                    item_arr_next  = s_tdata[18:8];
                    item_dur_next  = s_tdata[28:19];
                    pos_next       = count_reg[AW-1:0];
                    res_tag_next   = '0;
                    res_arr_next   = '0;
                    res_dur_next   = '0;
                    res_start_next = '0;
                    res_wait_next  = '0;
                    if (in_func == FUNC_ENQ)
                    begin
                        res_status_next = (count_reg == DEPTH_C) ? STAT_FULL : STAT_ENQ;
                    end
                    else
                    begin
                        res_status_next = (count_reg == '0) ? STAT_EMPTY : STAT_DEQ;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (do_shift)
                begin
                    pos_next = pos_reg - AW'(1);
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            ST_POP:
            begin
                res_tag_next   = ram_rdata[ENTRY_W-1:KEY_W];
                res_arr_next   = ram_rdata[KEY_W-1:DUR_W];
                res_dur_next   = ram_rdata[DUR_W-1:0];
                res_start_next = svc_rsp.start_min;
                res_wait_next  = svc_rsp.wait_min;
                count_next     = count_reg - CW'(1);
                head_next      = slot_of(head_reg, AW'(1));
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = OUT_W'({count_reg, svc_rsp.total_busy,
                                            svc_rsp.total_wait, res_wait_reg,
                                            res_start_reg, res_dur_reg,
                                            res_arr_reg, res_tag_reg});
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_tag_reg   <= item_tag_next;
        item_arr_reg   <= item_arr_next;
        item_dur_reg   <= item_dur_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_arr_reg    <= res_arr_next;
        res_dur_reg    <= res_dur_next;
        res_start_reg  <= res_start_next;
        res_wait_reg   <= res_wait_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------ assertions
    // never hold more jobs than the memory has slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("job count beyond queue depth");

    // an insert step never writes the slot it is prefetching
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == ST_SHIFT && do_shift && pos_reg > AW'(1))
            |-> (ram_waddr != ram_raddr))
        else $error("memory write collides with prefetch read");

    // an empty report shows zero occupancy
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STAT_EMPTY) |-> (m_tdata[125 +: CW] == '0))
        else $error("empty status with jobs held");

    // a full report shows a full queue
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STAT_FULL) |-> (m_tdata[125 +: CW] == DEPTH_C))
        else $error("full status with free slots");

endmodule

// ===== dv/jpq_checker.sv =====
// Scoreboard for the job priority queue scheduler: predicts every result and compares it.
module jpq_checker #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MW          = 136
) (
    input  logic          clk,
    input  logic          rst_n,

    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [31:0]   s_tdata,
    input  logic          s_tuser,

    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [MW-1:0] m_tdata,
    input  logic [1:0]    m_tuser,

    output int            errors,
    output int            pending,
    output int            jobs_held,
    output int            n_deq,
    output int            n_empty,
    output int            n_full,
    output int            n_clk_sat,
    output logic          wait_sat
);
    timeunit 1ns;
    timeprecision 1ps;

    import jpq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        status_t           status;
        logic [TAG_W-1:0]  tag;
        logic [ARR_W-1:0]  arr;
        logic [DUR_W-1:0]  dur;
        logic [TIME_W-1:0] start_min;
        logic [TIME_W-1:0] wait_min;
        logic [SUM_W-1:0]  tot_wait;
        logic [SUM_W-1:0]  tot_busy;
        logic [CW-1:0]     occ;
    } job_result_t;

    // Sorted job list of the model, front job at index 0
    logic [TAG_W-1:0] held_tag [QUEUE_DEPTH];
    logic [ARR_W-1:0] held_arr [QUEUE_DEPTH];
    logic [DUR_W-1:0] held_dur [QUEUE_DEPTH];

    int unsigned       svc_clock;
    longint unsigned   wait_total;
    longint unsigned   busy_total;
    job_result_t       due_results[$];
    job_result_t       oldest;

    function automatic longint unsigned sat_sum(longint unsigned acc,
                                                longint unsigned add);
        return (acc + add > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : acc + add;
    endfunction

    // Apply one job command to the model and return the result it must produce
    function automatic job_result_t schedule_job(logic fn, logic [TAG_W-1:0] tg,
                                                 logic [ARR_W-1:0] ar,
                                                 logic [DUR_W-1:0] du);
        job_result_t r;
        int          pos;
        int unsigned start_at;
        int unsigned finish_at;
        r = '0;
        if (fn == FUNC_ENQ)
        begin
            if (jobs_held >= QUEUE_DEPTH)
            begin
                r.status = STAT_FULL;
                n_full++;
            end
            else
            begin
                // land behind every job whose key is less or equal
                pos = jobs_held;
                while (pos > 0 && {held_arr[pos-1], held_dur[pos-1]} > {ar, du})
                begin
                    held_tag[pos] = held_tag[pos-1];
                    held_arr[pos] = held_arr[pos-1];
                    held_dur[pos] = held_dur[pos-1];
                    pos--;
                end
                held_tag[pos] = tg;
                held_arr[pos] = ar;
                held_dur[pos] = du;
                jobs_held++;
                r.status = STAT_ENQ;
            end
        end
        else if (jobs_held == 0)
        begin
            r.status = STAT_EMPTY;
            n_empty++;
        end
        else
        begin
            r.tag = held_tag[0];
            r.arr = held_arr[0];
            r.dur = held_dur[0];
            for (pos = 1; pos < jobs_held; pos++)
            begin
                held_tag[pos-1] = held_tag[pos];
                held_arr[pos-1] = held_arr[pos];
                held_dur[pos-1] = held_dur[pos];
            end
            jobs_held--;
            if (svc_clock == 65535)
                n_clk_sat++;
            start_at    = (svc_clock > r.arr) ? svc_clock : r.arr;
            r.start_min = start_at[TIME_W-1:0];
            r.wait_min  = TIME_W'(start_at - r.arr);
            finish_at   = start_at + r.dur;
            svc_clock   = (finish_at > 65535) ? 65535 : finish_at;
            wait_total  = sat_sum(wait_total, r.wait_min);
            busy_total  = sat_sum(busy_total, r.dur);
            r.status    = STAT_DEQ;
            n_deq++;
        end
        r.tot_wait = wait_total[SUM_W-1:0];
        r.tot_busy = busy_total[SUM_W-1:0];
        r.occ      = CW'(jobs_held);
        wait_sat   = (wait_total == 64'hFFFF_FFFF);
        return r;
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("chk: %0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            jobs_held  = 0;
            svc_clock  = 0;
            wait_total = 0;
            busy_total = 0;
            errors     = 0;
            pending    = 0;
            n_deq      = 0;
            n_empty    = 0;
            n_full     = 0;
            n_clk_sat  = 0;
            wait_sat   = 1'b0;
        end
        else
        begin
            // compare first: an item accepted now cannot have its result out yet
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("chk: %0t ns: result with none expected, %s %0d tdata %0h",
                             $time, "expected nothing, actual status", m_tuser, m_tdata);
                end
                else
                begin
                    oldest = due_results.pop_front();
                    check_field("status",       oldest.status,    m_tuser);
                    check_field("out_tag",      oldest.tag,       m_tdata[7:0]);
                    check_field("out_arrival",  oldest.arr,       m_tdata[18:8]);
                    check_field("out_duration", oldest.dur,       m_tdata[28:19]);
                    check_field("start_time",   oldest.start_min, m_tdata[44:29]);
                    check_field("wait_time",    oldest.wait_min,  m_tdata[60:45]);
                    check_field("total_wait",   oldest.tot_wait,  m_tdata[92:61]);
                    check_field("total_busy",   oldest.tot_busy,  m_tdata[124:93]);
                    check_field("occupancy",    oldest.occ,       m_tdata[125 +: CW]);
                    check_field("tdata pad",    '0,               m_tdata[MW-1:125+CW]);
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(schedule_job(s_tuser, s_tdata[7:0], s_tdata[18:8],
                                                   s_tdata[28:19]));
            pending = due_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Top of the scheduler testbench: clock, reset, job stimulus, stall patterns and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jpq_pkg::*;

    localparam int QD = 64;
    localparam int MW = ((125 + $clog2(QD + 1) + 7) / 8) * 8;

    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    // job_tag[7:0], arrival_minute[18:8], duration[28:19], zero[31:29]
    logic [31:0]   s_tdata  = '0;
    // func[0]
    logic          s_tuser  = FUNC_ENQ;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    // out_tag, out_arrival, out_duration, start_time, wait_time, total_wait,
    // total_busy, occupancy, zero pad
    logic [MW-1:0] m_tdata;
    // status[1:0]
    logic [1:0]    m_tuser;

    int   errors;
    int   pending;
    int   jobs_held;
    int   n_deq;
    int   n_empty;
    int   n_full;
    int   n_clk_sat;
    logic wait_sat;

    // Idling knobs, percent of cycles
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // Cycles left in a forced receiver hold-off
    int hold_cnt     = 0;
    // Rising time-of-day base for the well-ordered job streams
    int day          = 0;

    job_priority_queue_scheduler #(
        .QUEUE_DEPTH(QD)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    jpq_checker #(
        .QUEUE_DEPTH(QD),
        .MW         (MW)
    ) u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .jobs_held(jobs_held),
        .n_deq    (n_deq),
        .n_empty  (n_empty),
        .n_full   (n_full),
        .n_clk_sat(n_clk_sat),
        .wait_sat (wait_sat)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run with every insert at
    // full depth and the heaviest stalls
    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Result side: honor a forced hold-off first, else stall at random
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            m_tready <= 1'b0;
            hold_cnt = hold_cnt - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Offer one item from the falling edge, idling first at random, and
    // return at the rising edge that takes it. Valid stays high into the next
    // call, so a back-to-back item costs no bubble.
    task automatic put_item(logic fn, logic [TAG_W-1:0] tg, logic [ARR_W-1:0] ar,
                            logic [DUR_W-1:0] du);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {3'b000, du, ar, tg};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            1:
            begin
                tx_idle_pct  = 61;
                rx_stall_pct = 0;
            end
            2:
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 61;
            end
            default:
            begin
                tx_idle_pct  = 8;
                rx_stall_pct = 8;
            end
        endcase
    endtask

    // Draw one random job command. A timed stream has arrivals rising through
    // the day and short runs, so the service clock keeps crossing the arrivals
    // (some jobs start at once, some wait). An untimed one spreads keys over
    // the full 11-bit and 10-bit ranges with extra weight on the edges.
    task automatic random_job(int enq_pct, bit timed);
        logic             fn;
        logic [ARR_W-1:0] ar;
        logic [DUR_W-1:0] du;
        int               a;
        fn = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        if (timed)
        begin
            day = day + $urandom_range(0, 4);
            a   = day + $urandom_range(0, 40);
            ar  = (a > 2047) ? 11'd2047 : ARR_W'(a);
            du  = DUR_W'($urandom_range(0, 12));
        end
        else
        begin
            case ($urandom_range(9))
                0: ar = '0;
                1: ar = '1;
                2: ar = 11'd1439;
                default: ar = ARR_W'($urandom);
            endcase
            case ($urandom_range(9))
                0: du = '0;
                1: du = '1;
                default: du = DUR_W'($urandom);
            endcase
        end
        put_item(fn, TAG_W'($urandom), ar, du);
    endtask

    initial
    begin
        int enq_mix [8];
        int p;
        enq_mix = '{60, 92, 12, 50, 92, 20, 55, 50};

        // Hold reset, release away from the clock edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_idling(0);

        // Directed: empty dequeue, key extremes, arrival past the end of the
        // day, equal keys kept first-in-first-out, duration as tie-breaker
        put_item(FUNC_DEQ, 8'h00, '0, '0);
        put_item(FUNC_ENQ, 8'hFF, 11'd2047, 10'd1023);
        put_item(FUNC_ENQ, 8'h00, 11'd0, 10'd0);
        put_item(FUNC_ENQ, 8'h11, 11'd100, 10'd5);
        put_item(FUNC_ENQ, 8'h22, 11'd100, 10'd5);
        put_item(FUNC_ENQ, 8'h33, 11'd100, 10'd4);
        put_item(FUNC_ENQ, 8'h44, 11'd1439, 10'd0);
        put_item(FUNC_ENQ, 8'h55, 11'd100, 10'd5);
        put_item(FUNC_ENQ, 8'h66, 11'd1440, 10'd10);
        repeat (9) put_item(FUNC_DEQ, 8'hA5, 11'h5A5, 10'h2AA);

        // Random phases: rotate the idling pattern, swing the enqueue share
        // to fill the queue past full and to drain it past empty
        for (p = 0; p < 8; p++)
        begin
            set_idling(p % 4);
            repeat (180) random_job(enq_mix[p], p < 3);
        end

        // Drain completely before the next push
        set_idling(0);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);

        // Long receiver hold-off while jobs keep coming: the output register
        // fills and the block must stall its input
        @(posedge clk);
        hold_cnt = 400;
        repeat (30) random_job(70, 1'b0);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);

        // Empty the queue with dequeues at the running clock
        while (jobs_held != 0)
            put_item(FUNC_DEQ, 8'h00, '0, '0);

        // Quiet the input, wait out every result plus the worst insert
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge clk);

        $display("summary: %0d jobs served, %0d dequeues on an empty queue, %0d dropped full",
                 n_deq, n_empty, n_full);
        $display("summary: %0d dequeues at the saturated clock, wait total saturated: %0d",
                 n_clk_sat, wait_sat);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/jpq_pkg.sv
hdl/jpq_ram.sv
hdl/jpq_svc.sv
hdl/job_priority_queue_scheduler.sv
dv/jpq_checker.sv
dv/tb.sv
